// File: hw/rtl/abdc_pkg.sv
// Shared types, constants and helpers of the active bus discharge controller.
`default_nettype none

package abdc_pkg;

    // Control tick rates
    localparam int TICKS_PER_SECOND = 500;
    localparam int RECOVERY_TICKS   = 1000;

    // Field and register widths
    localparam int VOLT_W   = 16;
    localparam int SPEED_W  = 16;
    localparam int CUR_W    = 16;
    localparam int TSEC_W   = 7;
    localparam int RATED_W  = 14;
    localparam int TICKS_W  = 10;
    localparam int RUN_W    = 16;
    localparam int REC_W    = 10;
    localparam int ACC_W    = 24;
    localparam int TGT_W    = 22;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 24;

    // Limits
    localparam int RUN_MAX     = 65535;
    localparam int LIMIT_SAT   = 65534;
    localparam int SPEED_LIMIT = 512;
    localparam int VOLT_OFFSET = 320;
    localparam int END_MARGIN  = 160;

    // Reciprocals of 5 for exact floor division of bounded operands
    localparam logic [23:0] DIV5_M26 = 24'd13421773;
    localparam logic [24:0] DIV5_M27 = 25'd26843546;
    localparam logic [20:0] DIV5_M23 = 21'd1677722;

    // Filter bias keeps the divide-by-20 operand non-negative
    localparam int FILT_QBIAS = 63221;
    localparam int FILT_BIAS  = 20 * FILT_QBIAS;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SAFETY_VOLTAGE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_SECONDS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATED_CURRENT   = 2'd2;

    // Phase codes seen on the result
    localparam logic [1:0] PHASE_WAIT    = 2'd0;
    localparam logic [1:0] PHASE_RUN     = 2'd1;
    localparam logic [1:0] PHASE_END     = 2'd2;
    localparam logic [1:0] PHASE_TIMEOUT = 2'd3;

    typedef enum logic [3:0] {
        PH_WAIT    = 4'b0001,
        PH_RUN     = 4'b0010,
        PH_END     = 4'b0100,
        PH_TIMEOUT = 4'b1000
    } t_phase;

    // Configuration seen by the datapath
    typedef struct packed {
        logic [VOLT_W-1:0]        safety_voltage;
        logic [RUN_W-1:0]         tick_limit;
        logic signed [ACC_W-1:0]  clamp_lo;
    } t_cfg;

    // Pre-computed item handed to the sequencer
    typedef struct packed {
        logic                     mode;
        logic                     req;
        logic                     cal;
        logic                     speed_ok;
        logic                     bus_ok;
        logic                     end_hit;
        logic                     under_sv;
        logic signed [TGT_W-1:0]  target;
    } t_prep;

    function automatic logic [1:0] phase_code(input t_phase ph);
        logic [1:0] code;
        unique case (ph)
            PH_WAIT:    code = PHASE_WAIT;
            PH_RUN:     code = PHASE_RUN;
            PH_END:     code = PHASE_END;
            PH_TIMEOUT: code = PHASE_TIMEOUT;
            default:    code = PHASE_WAIT;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/active_bus_discharge_controller_unit.sv
// Top level of the active bus discharge controller.
//
// Channel   Dir  Handshake                       Payload
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tdata: input item, 56 bits
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tdata: result item, 24 bits
// cfg       in   i_cfg_we                         i_cfg_idx, i_cfg_wdata
//
// Three register stages: input, pre-compute (target current, compares),
// sequencer/result. One item per cycle sustained while results are accepted;
// the sequencer state loop closes through one register.
// Synchronous active-low reset clears phase, filter, counters and config.
// A stalled result register stalls earlier stages only as they fill.
// Derived config limits settle in the cycle after a register write.
`default_nettype none

module active_bus_discharge_controller_unit import abdc_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // [0] in_discharge_mode, [1] discharge_request, [2] offset_cal_done,
    // [18:3] rotor_speed, [34:19] bus_voltage, [50:35] bus_voltage_filtered
    input  wire logic [IN_TDATA_W-1:0]   i_s_axis_tdata,
    input  wire logic                    i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // [15:0] d_current_ref, [16] setpoint_write, [17] drive_disable,
    // [18] undervolt_flag_set, [19] low_power_request, [21:20] phase
    output logic [OUT_TDATA_W-1:0]       o_m_axis_tdata,
    output logic                         o_m_axis_tvalid,
    input  wire logic                    i_m_axis_tready,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_wdata
);

    t_cfg   cfg;
    t_prep  prep;
    logic   prep_valid;
    logic   seq_ready;

    abdc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    abdc_prep u_prep (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_s_tvalid       (i_s_axis_tvalid),
        .o_s_tready       (o_s_axis_tready),
        .i_s_tdata        (i_s_axis_tdata),
        .i_safety_voltage (cfg.safety_voltage),
        .o_valid          (prep_valid),
        .i_ready          (seq_ready),
        .o_prep           (prep)
    );

    abdc_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (prep_valid),
        .o_ready    (seq_ready),
        .i_prep     (prep),
        .i_cfg      (cfg),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_m_tdata  (o_m_axis_tdata)
    );

endmodule

`default_nettype wire

// File: hw/rtl/abdc_cfg.sv
// Configuration registers and the limits derived from them.
`default_nettype none

module abdc_cfg import abdc_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                       o_cfg
);

    localparam int PROD_W = TSEC_W + TICKS_W;

    logic [VOLT_W-1:0]        r_safety_voltage;
    logic [TSEC_W-1:0]        r_timeout_seconds;
    logic [RATED_W-1:0]       r_rated_current;
    logic [RUN_W-1:0]         r_tick_limit;
    logic signed [ACC_W-1:0]  r_clamp_lo;

    logic [RUN_W-1:0]         n_tick_limit;
    logic signed [ACC_W-1:0]  n_clamp_lo;
    logic [PROD_W-1:0]        limit_full;
    logic [24:0]              lo_num;
    logic [50:0]              lo_prod;
    logic [ACC_W-1:0]         lo_mag;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_safety_voltage  <= '0;
            r_timeout_seconds <= '0;
            r_rated_current   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SAFETY_VOLTAGE:  r_safety_voltage  <= i_cfg_wdata[VOLT_W-1:0];
                CFG_TIMEOUT_SECONDS: r_timeout_seconds <= i_cfg_wdata[TSEC_W-1:0];
                CFG_RATED_CURRENT:   r_rated_current   <= i_cfg_wdata[RATED_W-1:0];
                default: ;
            endcase
        end
    end

    // Derive run tick limit (saturated) and lower reference clamp
    always_comb begin
        limit_full = PROD_W'(r_timeout_seconds) * PROD_W'(TICKS_PER_SECOND);
        if (limit_full > PROD_W'(LIMIT_SAT)) begin
            n_tick_limit = RUN_W'(LIMIT_SAT);
        end else begin
            n_tick_limit = limit_full[RUN_W-1:0];
        end
        lo_num     = 25'(r_rated_current) * 25'd1664 + 25'd2;
        lo_prod    = 51'(lo_num) * 51'(DIV5_M27);
        lo_mag     = lo_prod[27 +: ACC_W];
        n_clamp_lo = -$signed(lo_mag);
    end

    // Register derived values behind the config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_limit <= '0;
            r_clamp_lo   <= '0;
        end else begin
            r_tick_limit <= n_tick_limit;
            r_clamp_lo   <= n_clamp_lo;
        end
    end

    assign o_cfg.safety_voltage = r_safety_voltage;
    assign o_cfg.tick_limit     = r_tick_limit;
    assign o_cfg.clamp_lo       = r_clamp_lo;

endmodule

`default_nettype wire

// File: hw/rtl/abdc_prep.sv
// Input register and pre-compute stage: threshold compares and current target.
`default_nettype none

module abdc_prep import abdc_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,
    input  wire logic [VOLT_W-1:0]      i_safety_voltage,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output t_prep                       o_prep
);

    localparam int RAW_W = 3 + SPEED_W + 2 * VOLT_W;

    logic               r_a_valid;
    logic [RAW_W-1:0]   r_a_data;
    logic               r_b_valid;
    t_prep              r_b_prep;

    logic               a_ready;
    logic               b_ready;
    t_prep              n_b_prep;

    logic signed [SPEED_W-1:0] speed;
    logic [VOLT_W-1:0]         udc;
    logic [VOLT_W-1:0]         ufilt;
    logic signed [17:0]        volt_err;
    logic signed [17:0]        volt_neg;
    logic [16:0]               err_mag;
    logic [22:0]               scaled;
    logic [46:0]               quo_prod;
    logic [TGT_W-2:0]          quo;

    // Stage handshake
    assign b_ready    = !r_b_valid || i_ready;
    assign a_ready    = !r_a_valid || b_ready;
    assign o_s_tready = a_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_valid <= i_s_tvalid;
            end
            if (b_ready) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    // Capture the transfer
    always_ff @(posedge i_clk) begin
        if (a_ready && i_s_tvalid) begin
            r_a_data <= i_s_tdata[RAW_W-1:0];
        end
    end

    // Compares and target current from the bus voltage error
    always_comb begin
        speed    = $signed(r_a_data[3 +: SPEED_W]);
        udc      = r_a_data[3 + SPEED_W +: VOLT_W];
        ufilt    = r_a_data[3 + SPEED_W + VOLT_W +: VOLT_W];
        volt_err = $signed({2'b00, i_safety_voltage}) - 18'sd320
                   - $signed({2'b00, udc});
        volt_neg = -volt_err;
        err_mag  = volt_neg[16:0];
        scaled   = 23'(err_mag) * 23'd96 + 23'd2;
        quo_prod = 47'(scaled) * 47'(DIV5_M26);
        quo      = quo_prod[26 +: TGT_W-1];

        n_b_prep.mode     = r_a_data[0];
        n_b_prep.req      = r_a_data[1];
        n_b_prep.cal      = r_a_data[2];
        n_b_prep.speed_ok = (speed >= -16'sd512) && (speed <= 16'sd512);
        n_b_prep.bus_ok   = udc >= i_safety_voltage;
        n_b_prep.end_hit  = ({1'b0, ufilt} + 17'd160) < {1'b0, i_safety_voltage};
        n_b_prep.under_sv = ufilt < i_safety_voltage;
        n_b_prep.target   = volt_err[17] ? -$signed({1'b0, quo}) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (b_ready && r_a_valid) begin
            r_b_prep <= n_b_prep;
        end
    end

    assign o_valid = r_b_valid;
    assign o_prep  = r_b_prep;

endmodule

`default_nettype wire

// File: hw/rtl/abdc_seq.sv
// Discharge phase sequencer, reference filter and result register.
`default_nettype none

module abdc_seq import abdc_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  t_prep                        i_prep,
    input  t_cfg                         i_cfg,
    output logic                         o_m_tvalid,
    input  wire logic                    i_m_tready,
    output logic [OUT_TDATA_W-1:0]       o_m_tdata
);

    t_phase                   r_phase, n_phase;
    logic signed [ACC_W-1:0]  r_acc, n_acc;
    logic [RUN_W-1:0]         r_run, n_run;
    logic [REC_W-1:0]         r_rec, n_rec;
    logic                     r_valid;
    logic signed [CUR_W-1:0]  r_dref, n_dref;
    logic                     r_wr, n_wr;
    logic                     r_dis, n_dis;
    logic                     r_uv, n_uv;
    logic                     r_lp, n_lp;
    logic [1:0]               r_code;

    logic                     fire;
    logic [RUN_W-1:0]         run_inc;
    logic [REC_W-1:0]         rec_inc;
    logic signed [24:0]       tgt_x;
    logic signed [24:0]       filt_w;
    logic signed [24:0]       filt_wb;
    logic [20:0]              filt_x;
    logic [41:0]              filt_prod;
    logic [18:0]              filt_q;
    logic signed [24:0]       acc_f;
    logic signed [24:0]       acc_s;
    logic signed [24:0]       acc_c;
    logic signed [ACC_W-1:0]  acc_new;
    logic signed [ACC_W-1:0]  acc_rnd;

    assign o_ready = !r_valid || i_m_tready;
    assign fire    = i_valid && o_ready;

    // Filter: acc + floor((t + 10 - acc) / 20), snap up, clamp
    always_comb begin
        tgt_x     = 25'(i_prep.target);
        filt_w    = tgt_x + 25'sd10 - 25'(r_acc);
        filt_wb   = filt_w + 25'(FILT_BIAS);
        filt_x    = filt_wb[22:2];
        filt_prod = 42'(filt_x) * 42'(DIV5_M23);
        filt_q    = filt_prod[23 +: 19];
        acc_f     = 25'(r_acc) + $signed({6'b0, filt_q}) - 25'sd63221;
        acc_s     = (acc_f < tgt_x) ? tgt_x : acc_f;
        acc_c     = (acc_s > 25'sd0) ? 25'sd0 : acc_s;
        if (acc_c < 25'(i_cfg.clamp_lo)) begin
            acc_c = 25'(i_cfg.clamp_lo);
        end
        acc_new   = acc_c[ACC_W-1:0];
        acc_rnd   = acc_new + 24'sd128;
    end

    // Phase sequencing
    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_run   = r_run;
        n_rec   = r_rec;
        n_dref  = '0;
        n_wr    = 1'b0;
        n_dis   = 1'b0;
        n_uv    = 1'b0;
        n_lp    = 1'b0;
        run_inc = (r_run == RUN_W'(RUN_MAX)) ? r_run : r_run + 1'b1;
        rec_inc = r_rec + 1'b1;
        if (!i_prep.mode) begin
            n_phase = PH_WAIT;
            n_acc   = '0;
            n_run   = '0;
            n_rec   = '0;
        end else begin
            unique case (r_phase)
                PH_WAIT: begin
                    if (i_prep.req && i_prep.cal && i_prep.speed_ok && i_prep.bus_ok) begin
                        n_phase = PH_RUN;
                    end
                end
                PH_RUN: begin
                    if (i_prep.end_hit) begin
                        n_phase = PH_END;
                        n_run   = '0;
                    end else if (run_inc > i_cfg.tick_limit) begin
                        n_phase = PH_TIMEOUT;
                        n_run   = '0;
                    end else begin
                        n_run  = run_inc;
                        n_acc  = acc_new;
                        n_dref = acc_rnd[8 +: CUR_W];
                        n_wr   = 1'b1;
                    end
                end
                PH_END: begin
                    n_acc   = '0;
                    n_wr    = 1'b1;
                    n_dis   = 1'b1;
                    n_uv    = 1'b1;
                    n_lp    = 1'b1;
                    n_phase = PH_WAIT;
                end
                PH_TIMEOUT: begin
                    n_acc = '0;
                    n_wr  = 1'b1;
                    n_rec = rec_inc;
                    priority if (rec_inc >= REC_W'(RECOVERY_TICKS)) begin
                        n_rec   = '0;
                        n_phase = PH_WAIT;
                    end else if (i_prep.under_sv) begin
                        n_dis   = 1'b1;
                        n_uv    = 1'b1;
                        n_lp    = 1'b1;
                        n_rec   = '0;
                        n_phase = PH_WAIT;
                    end
                end
                default: n_phase = PH_WAIT;
            endcase
        end
    end

    // Advance state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT;
            r_acc   <= '0;
            r_run   <= '0;
            r_rec   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_phase <= n_phase;
                r_acc   <= n_acc;
                r_run   <= n_run;
                r_rec   <= n_rec;
            end
            if (o_ready) begin
                r_valid <= i_valid;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_dref <= n_dref;
            r_wr   <= n_wr;
            r_dis  <= n_dis;
            r_uv   <= n_uv;
            r_lp   <= n_lp;
            r_code <= phase_code(n_phase);
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {2'b00, r_code, r_lp, r_uv, r_dis, r_wr, r_dref};

    // Checks
    a_acc_nonpos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc <= 24'sd0)
        else $error("accumulator went positive");
    a_acc_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && i_prep.mode && r_phase == PH_RUN && n_wr) |=> r_acc >= $past(i_cfg.clamp_lo))
        else $error("accumulator below clamp");
    a_idle_ref: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_wr) |-> r_dref == '0)
        else $error("reference driven without setpoint write");
    a_pulses: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_dis == r_uv) && (r_uv == r_lp) && (!r_dis || r_wr))
        else $error("shutdown pulses out of step");

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// Testbench of the active bus discharge controller: predicted results checked over stream traffic.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import abdc_pkg::*;

    // Tracks the discharge sequence and holds the results still owed by the block
    class discharge_scoreboard;
        logic [VOLT_W-1:0]   safety = '0;
        logic [TSEC_W-1:0]   timeout_s = '0;
        logic [RATED_W-1:0]  rated = '0;

        logic [1:0]          phase = PHASE_WAIT;
        longint              accum = 0;
        int unsigned         run_ticks = 0;
        logic [REC_W-1:0]    recov_ticks = '0;

        logic [OUT_TDATA_W-1:0] expected_results[$];
        int mismatches = 0;
        int items_taken = 0;
        int results_seen = 0;
        int runs_entered = 0;
        int runs_ended = 0;
        int runs_timed_out = 0;
        int recoveries = 0;
        int mode_drops = 0;

        static function longint floor_div(longint n, longint den);
            longint q;
            q = n / den;
            if ((n % den) != 0 && n < 0)
                q = q - 1;
            return q;
        endfunction

        function void set_config(logic [VOLT_W-1:0] sv, logic [TSEC_W-1:0] tsec,
                                 logic [RATED_W-1:0] rc);
            safety = sv;
            timeout_s = tsec;
            rated = rc;
        endfunction

        // Advance the sequencer by one tick and queue the result it owes
        function void take_item(logic [IN_TDATA_W-1:0] item);
            bit mode, req, cal;
            logic signed [SPEED_W-1:0] speed;
            int udc, ufilt, sv, mag;
            longint d, tgt, acc, lo;
            int unsigned limit;
            logic [CUR_W-1:0] dref;
            bit wr, dis, uv, lp;

            mode = item[0];
            req = item[1];
            cal = item[2];
            speed = item[18:3];
            udc = item[34:19];
            ufilt = item[50:35];
            sv = safety;
            dref = '0;
            wr = 0;
            dis = 0;
            uv = 0;
            lp = 0;
            items_taken++;

            if (!mode) begin
                if (phase != PHASE_WAIT)
                    mode_drops++;
                accum = 0;
                run_ticks = 0;
                recov_ticks = '0;
                phase = PHASE_WAIT;
            end else begin
                case (phase)
                    PHASE_WAIT: begin
                        mag = (speed < 0) ? -int'(speed) : int'(speed);
                        if (req && cal && mag <= SPEED_LIMIT && udc >= sv) begin
                            phase = PHASE_RUN;
                            runs_entered++;
                        end
                    end
                    PHASE_RUN: begin
                        if (ufilt < sv - END_MARGIN) begin
                            phase = PHASE_END;
                            run_ticks = 0;
                            runs_ended++;
                        end else begin
                            limit = timeout_s * TICKS_PER_SECOND;
                            if (limit > LIMIT_SAT)
                                limit = LIMIT_SAT;
                            if (run_ticks < RUN_MAX)
                                run_ticks++;
                            if (run_ticks > limit) begin
                                run_ticks = 0;
                                phase = PHASE_TIMEOUT;
                                runs_timed_out++;
                            end else begin
                                // 0.075 A per volt below the offset threshold, Q16.8
                                d = longint'(sv) - VOLT_OFFSET - udc;
                                tgt = (d < 0) ? -((-d * 96 + 2) / 5) : 0;
                                acc = floor_div(19 * accum + tgt + 10, 20);
                                if (acc < tgt)
                                    acc = tgt;
                                lo = -((longint'(rated) * 1664 + 2) / 5);
                                if (acc > 0)
                                    acc = 0;
                                if (acc < lo)
                                    acc = lo;
                                accum = acc;
                                dref = CUR_W'(floor_div(acc + 128, 256));
                                wr = 1;
                            end
                        end
                    end
                    PHASE_END: begin
                        accum = 0;
                        wr = 1;
                        dis = 1;
                        uv = 1;
                        lp = 1;
                        phase = PHASE_WAIT;
                    end
                    default: begin
                        accum = 0;
                        wr = 1;
                        recov_ticks = recov_ticks + 1'b1;
                        if (recov_ticks >= RECOVERY_TICKS) begin
                            recov_ticks = '0;
                            phase = PHASE_WAIT;
                            recoveries++;
                        end else if (ufilt < sv) begin
                            dis = 1;
                            uv = 1;
                            lp = 1;
                            recov_ticks = '0;
                            phase = PHASE_WAIT;
                        end
                    end
                endcase
            end
            expected_results.push_back({2'b00, phase, lp, uv, dis, wr, dref});
        endfunction

        function string show(logic [OUT_TDATA_W-1:0] r);
            return $sformatf("ref=%0d wr=%b dis=%b uv=%b lp=%b phase=%0d",
                             $signed(r[15:0]), r[16], r[17], r[18], r[19], r[21:20]);
        endfunction

        // Compare one result transfer with the oldest outstanding prediction
        function void check_result(logic [OUT_TDATA_W-1:0] got);
            logic [OUT_TDATA_W-1:0] want;
            string diff;
            diff = "";
            results_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected result: %s", $time, show(got));
                return;
            end
            want = expected_results.pop_front();
            if (got[15:0] !== want[15:0])
                diff = {diff, " d_current_ref"};
            if (got[16] !== want[16])
                diff = {diff, " setpoint_write"};
            if (got[17] !== want[17])
                diff = {diff, " drive_disable"};
            if (got[18] !== want[18])
                diff = {diff, " undervolt_flag_set"};
            if (got[19] !== want[19])
                diff = {diff, " low_power_request"};
            if (got[21:20] !== want[21:20])
                diff = {diff, " phase"};
            if (diff != "") begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] result %0d wrong in%s: expected %s, actual %s",
                             $time, results_seen, diff, show(want), show(got));
            end
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    // [0] mode, [1] request, [2] cal done, [18:3] speed, [34:19] bus, [50:35] bus filtered
    logic [IN_TDATA_W-1:0]   i_s_axis_tdata = '0;
    logic                    i_s_axis_tvalid = 1'b0;
    logic                    o_s_axis_tready;
    // [15:0] d ref, [16] setpoint write, [17] disable, [18] undervolt, [19] low power,
    // [21:20] phase
    logic [OUT_TDATA_W-1:0]  o_m_axis_tdata;
    logic                    o_m_axis_tvalid;
    logic                    i_m_axis_tready = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx = CFG_SAFETY_VOLTAGE;
    logic [CFG_DATA_W-1:0]   i_cfg_wdata = '0;

    discharge_scoreboard sb = new;

    int tx_idle_pct = 7;
    int rx_idle_pct = 53;
    int noise_pct = 4;
    int run_end_pct = 6;
    int recover_exit_pct = 4;
    int stall_asks = 0;
    int stall_served = 0;
    int stall_left = 0;

    active_bus_discharge_controller_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Receiver: random back-pressure, plus a long hold-off whenever one is asked for
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (stall_left != 0) begin
            i_m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (stall_served != stall_asks) begin
            stall_served <= stall_asks;
            stall_left <= 300;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Check every result transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_result(o_m_axis_tdata);
    end

    function automatic logic [IN_TDATA_W-1:0] pack_item(bit mode, bit req, bit cal,
            logic [15:0] speed, logic [15:0] udc, logic [15:0] ufilt);
        return {5'b0, ufilt, udc, speed, cal, req, mode};
    endfunction

    function automatic logic [15:0] in_range(int lo, int hi);
        if (lo < 0) lo = 0;
        if (hi < 0) hi = 0;
        if (lo > 65535) lo = 65535;
        if (hi > 65535) hi = 65535;
        return 16'($urandom_range(hi, lo));
    endfunction

    // Shape the next tick so the sequence keeps moving through its phases
    function automatic logic [IN_TDATA_W-1:0] next_item();
        int sv;
        bit req, cal;
        logic [15:0] speed, udc, ufilt;
        sv = sb.safety;
        if ($urandom_range(99) < noise_pct)
            return pack_item(1'($urandom), 1'($urandom), 1'($urandom),
                             16'($urandom), 16'($urandom), 16'($urandom));
        req = 1;
        cal = 1;
        speed = 16'($urandom);
        udc = 16'($urandom);
        ufilt = 16'($urandom);
        case (sb.phase)
            PHASE_WAIT: begin
                req = ($urandom_range(9) != 0);
                cal = ($urandom_range(9) != 0);
                if ($urandom_range(4) != 0)
                    speed = 16'($urandom_range(2 * SPEED_LIMIT) - SPEED_LIMIT);
                if ($urandom_range(4) != 0)
                    udc = in_range(sv, sv + 2000);
            end
            PHASE_RUN: begin
                if ($urandom_range(3) != 0)
                    udc = in_range(sv - VOLT_OFFSET - 20000, sv - VOLT_OFFSET);
                if ($urandom_range(99) < run_end_pct)
                    ufilt = in_range(0, sv - END_MARGIN - 1);
                else
                    ufilt = in_range(sv - END_MARGIN, 65535);
            end
            PHASE_TIMEOUT: begin
                if ($urandom_range(99) < recover_exit_pct)
                    ufilt = in_range(0, sv - 1);
                else
                    ufilt = in_range(sv, 65535);
            end
            default: ;
        endcase
        return pack_item(1'b1, req, cal, speed, udc, ufilt);
    endfunction

    // Offer one item, with random sender gaps, until it transfers
    task automatic send_item(logic [IN_TDATA_W-1:0] item);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= item;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        sb.take_item(item);
    endtask

    task automatic send_random(int count);
        repeat (count)
            send_item(next_item());
    endtask

    // Stop offering and wait until every predicted result has transferred
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write all three registers while the block is idle
    task automatic configure(logic [VOLT_W-1:0] sv, logic [TSEC_W-1:0] tsec,
                             logic [RATED_W-1:0] rc);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_SAFETY_VOLTAGE;
        i_cfg_wdata <= sv;
        @(posedge i_clk);
        i_cfg_idx <= CFG_TIMEOUT_SECONDS;
        i_cfg_wdata <= CFG_DATA_W'(tsec);
        @(posedge i_clk);
        i_cfg_idx <= CFG_RATED_CURRENT;
        i_cfg_wdata <= CFG_DATA_W'(rc);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_config(sv, tsec, rc);
        // let the derived limits settle
        repeat (3) @(posedge i_clk);
    endtask

    initial begin
        #1_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset configuration: zero threshold enters run, zero limit times out at once
        send_item(pack_item(0, 1, 1, 16'h7FFF, 16'hFFFF, 16'hFFFF));
        send_item(pack_item(1, 1, 1, 16'h0000, 16'h0000, 16'h0000));
        send_item(pack_item(1, 0, 0, 16'h8000, 16'h0000, 16'h0000));
        send_item(pack_item(1, 0, 0, 16'h0000, 16'h0000, 16'h0000));
        send_item(pack_item(0, 0, 0, 16'h0000, 16'h0000, 16'h0000));

        // Entry conditions one at a time, then timeout and early voltage exit
        configure(16'd8000, 7'd0, 14'd1000);
        send_item(pack_item(1, 1, 1, 16'd513, 16'hFFFF, 16'd0));
        send_item(pack_item(1, 1, 1, 16'(-513), 16'hFFFF, 16'd0));
        send_item(pack_item(1, 1, 1, 16'(-512), 16'd7999, 16'd0));
        send_item(pack_item(1, 0, 1, 16'd0, 16'hFFFF, 16'd0));
        send_item(pack_item(1, 1, 0, 16'd0, 16'hFFFF, 16'd0));
        send_item(pack_item(1, 1, 1, 16'd512, 16'd8000, 16'd0));
        send_item(pack_item(1, 1, 1, 16'd0, 16'd0, 16'hFFFF));
        send_item(pack_item(1, 1, 1, 16'd0, 16'd0, 16'd8000));
        send_item(pack_item(1, 1, 1, 16'd0, 16'd0, 16'd7999));

        // Filter, snap up, end margin, end tick, mode drop mid-run
        configure(16'd8000, 7'd1, 14'd16383);
        send_item(pack_item(1, 1, 1, 16'd0, 16'hFFFF, 16'hFFFF));
        send_item(pack_item(1, 1, 1, 16'd0, 16'd0, 16'hFFFF));
        send_item(pack_item(1, 1, 1, 16'd0, 16'd0, 16'hFFFF));
        send_item(pack_item(1, 1, 1, 16'd0, 16'hFFFF, 16'hFFFF));
        send_item(pack_item(1, 1, 1, 16'd0, 16'd7680, 16'd7840));
        send_item(pack_item(1, 1, 1, 16'd0, 16'd0, 16'd7839));
        send_item(pack_item(1, 0, 0, 16'd0, 16'd0, 16'd0));
        send_item(pack_item(1, 1, 1, 16'd0, 16'hFFFF, 16'hFFFF));
        send_item(pack_item(0, 1, 1, 16'd0, 16'd0, 16'hFFFF));

        // Threshold under 10 V: run never ends on voltage
        configure(16'd100, 7'd1, 14'd16383);
        send_item(pack_item(1, 1, 1, 16'd0, 16'd100, 16'd0));
        send_item(pack_item(1, 1, 1, 16'd0, 16'd0, 16'd0));

        // Slow receiver, with one long hold-off that backs up the input
        configure(16'($urandom_range(12000, 3000)), 7'd1, 14'($urandom_range(16383)));
        send_random(100);
        stall_asks++;
        send_random(100);

        // Slow sender at the register extremes, with one full pause
        tx_idle_pct = 53;
        rx_idle_pct = 7;
        configure(16'hFFFF, 7'd127, 14'd16383);
        send_random(80);
        drain();
        send_random(80);
        noise_pct = 8;
        configure(16'd0, 7'd0, 14'd0);
        send_random(60);

        // No idling: immediate run timeouts and early exits from the recovery wait
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        noise_pct = 0;
        run_end_pct = 0;
        recover_exit_pct = 10;
        configure(16'd100, 7'd0, 14'($urandom_range(16383)));
        send_random(150);

        noise_pct = 4;
        run_end_pct = 6;
        recover_exit_pct = 4;
        configure(16'($urandom_range(12000, 160)), 7'($urandom_range(2)),
                  14'($urandom_range(16383)));
        send_random(200);

        drain();
        repeat (10) @(posedge i_clk);

        $display("Ticks sent %0d, results checked %0d, mismatches %0d",
                 sb.items_taken, sb.results_seen, sb.mismatches);
        $display("Runs entered %0d, ended on voltage %0d, timed out %0d, recovered %0d, %s %0d",
                 sb.runs_entered, sb.runs_ended, sb.runs_timed_out, sb.recoveries,
                 "mode drops", sb.mode_drops);
        if (sb.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/abdc_pkg.sv
hw/rtl/abdc_cfg.sv
hw/rtl/abdc_prep.sv
hw/rtl/abdc_seq.sv
hw/rtl/active_bus_discharge_controller_unit.sv
bench/tb_top.sv
